// ===== hdl/trtp_pkg.sv =====
// shared types and constants for the timed release task picker
// no dependencies
`timescale 1ns / 1ps
package trtp_pkg;
    localparam int DEF_TABLE_DEPTH = 16;
    localparam logic [15:0] NEAR_WINDOW_RST = 16'd100;
    localparam int REL_W = 49;
    localparam int TAG_W = 16;
    localparam int NOW_W = 48;
    localparam int ENT_W = REL_W + TAG_W;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_PICK   = 1'b1;

    localparam logic [0:0] REG_FIFO_MODE   = 1'd0;
    localparam logic [0:0] REG_NEAR_WINDOW = 1'd1;

    // pick scan stage: which rule currently holds the best candidate
    localparam logic [1:0] CAT_NONE = 2'd0;
    localparam logic [1:0] CAT_NEAR = 2'd1;
    localparam logic [1:0] CAT_OVER = 2'd2;
    localparam logic [1:0] CAT_IMM  = 2'd3;
endpackage

// ===== hdl/trtp_table.sv =====
// task table memory: one synchronous port set, registered read data
// depends on trtp_pkg
`timescale 1ns / 1ps
module trtp_table
    import trtp_pkg::*;
#(
    parameter int DEPTH = DEF_TABLE_DEPTH,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [ENT_W-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [ENT_W-1:0] o_rdata
);
    logic [ENT_W-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hdl/timed_release_task_picker_top.sv =====
// timed release task picker top: sequencer, apb registers and output register
// depends on trtp_pkg and trtp_table
// insert, empty and full answers: the request goes through S_OUT, which sets the result valid.
// pick: one memory read per scanned entry (the scan stops at an immediate entry or at
// once in fifo mode), then one read plus one write per moved entry. one request at a
// time: the next one is accepted only in idle, when no result is pending or it is being taken
// synchronous active-low reset clears count and control and sets the apb registers to defaults;
// table memory content is not cleared and only entries below the entry count are used
`timescale 1ns / 1ps
module timed_release_task_picker_top
    import trtp_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_mode,
    input  logic [TAG_W-1:0]         i_task_tag,
    input  logic signed [REL_W-1:0]  i_release_time,
    input  logic [NOW_W-1:0]         i_now_time,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [1:0]               o_status,
    output logic [TAG_W-1:0]         o_picked_tag,
    output logic signed [REL_W-1:0]  o_picked_release,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_TAKE  = 6'b000100,
        S_MRD   = 6'b001000,
        S_MWR   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic r_fifo;
    logic [15:0] r_win;
    logic [NOW_W-1:0] r_now;
    logic [CW-1:0] r_idx, n_idx;      // address issued
    logic [CW-1:0] r_didx, n_didx;    // index of data arriving
    logic r_dv, n_dv;
    logic [1:0] r_cat, n_cat;
    logic [AW-1:0] r_best, n_best;
    logic [REL_W-1:0] r_gap, n_gap;
    logic [ENT_W-1:0] r_bent, n_bent;
    logic r_ovalid, n_ovalid;
    logic [1:0] r_ost, n_ost;
    logic [ENT_W-1:0] r_oent, n_oent;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [ENT_W-1:0] wdata, rdata;

    trtp_table #(.DEPTH(TABLE_DEPTH)) u_table (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    // apb registers
    assign pready = 1'b1;
    logic [0:0] reg_idx;
    assign reg_idx = paddr[2];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fifo <= 1'b0;
            r_win  <= NEAR_WINDOW_RST;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_FIFO_MODE:   r_fifo <= pwdata[0];
                REG_NEAR_WINDOW: r_win  <= pwdata[15:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_FIFO_MODE:   prdata = {31'd0, r_fifo};
            REG_NEAR_WINDOW: prdata = {16'd0, r_win};
            default: ;
        endcase
    end

    // candidate evaluation of the entry read back during the scan
    logic signed [REL_W-1:0] e_rel;
    logic signed [REL_W+1:0] e_now, e_diff;
    logic [1:0] e_cat;
    logic [REL_W-1:0] e_gap;
    logic e_better;
    assign e_rel  = rdata[ENT_W-1:TAG_W];
    assign e_now  = $signed({3'b000, r_now});
    assign e_diff = e_now - $signed({{2{e_rel[REL_W-1]}}, e_rel});
    always_comb begin
        e_cat = CAT_NONE;
        e_gap = '0;
        if (e_rel == -49'sd1) begin
            e_cat = CAT_IMM;
        end else if (!e_diff[REL_W+1]) begin
            e_cat = CAT_OVER;
            e_gap = e_diff[REL_W-1:0];
        end else if (-e_diff <= $signed({35'd0, r_win})) begin
            e_cat = CAT_NEAR;
            e_gap = REL_W'(-e_diff);
        end
        e_better = 1'b0;
        if (e_cat > r_cat) begin
            e_better = 1'b1;
        end else if (e_cat == r_cat) begin
            case (e_cat)
                CAT_OVER: e_better = e_gap > r_gap;
                CAT_NEAR: e_better = e_gap < r_gap;
                default:  e_better = 1'b0;
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state; n_count = r_count; n_idx = r_idx; n_didx = r_didx;
        n_dv = 1'b0; n_cat = r_cat; n_best = r_best; n_gap = r_gap;
        n_bent = r_bent; n_ovalid = r_ovalid; n_ost = r_ost; n_oent = r_oent;
        we = 1'b0; waddr = r_idx[AW-1:0]; wdata = rdata; raddr = r_idx[AW-1:0];
        o_ready = 1'b0;
        if (r_ovalid && i_ready) n_ovalid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = !r_ovalid || i_ready;
                if (i_valid && o_ready) begin
                    n_oent = '0;
                    if (i_mode == MODE_INSERT) begin
                        if (r_count == CW'(TABLE_DEPTH)) begin
                            n_ost = ST_FULL;
                        end else begin
                            we = 1'b1;
                            waddr = r_count[AW-1:0];
                            wdata = {i_release_time, i_task_tag};
                            n_count = r_count + 1'b1;
                            n_ost = ST_OK;
                        end
                        n_state = S_OUT;
                    end else if (r_count == '0) begin
                        n_ost = ST_EMPTY;
                        n_state = S_OUT;
                    end else begin
                        raddr = '0;
                        n_idx = CW'(1);
                        n_didx = '0;
                        n_dv = 1'b1;
                        n_cat = CAT_NONE;
                        n_gap = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // stream reads, evaluate each returned entry
                raddr = r_idx[AW-1:0];
                if (r_dv) begin
                    if (r_fifo || e_better) begin
                        n_cat = r_fifo ? CAT_IMM : e_cat;
                        n_best = r_didx[AW-1:0];
                        n_gap = e_gap;
                        n_bent = rdata;
                    end
                    if (r_fifo || (!r_fifo && e_cat == CAT_IMM)
                        || r_didx + 1'b1 == r_count) begin
                        n_state = S_TAKE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                        n_didx = r_didx + 1'b1;
                        n_dv = 1'b1;
                    end
                end
            end
            S_TAKE: begin
                if (r_cat == CAT_NONE) begin
                    n_ost = ST_NONE;
                    n_oent = '0;
                    n_state = S_OUT;
                end else begin
                    n_ost = ST_OK;
                    n_oent = r_bent;
                    n_idx = CW'(r_best) + 1'b1;
                    n_state = (CW'(r_best) + 1'b1 < r_count) ? S_MRD : S_MWR;
                    if (!(CW'(r_best) + 1'b1 < r_count)) begin
                        n_count = r_count - 1'b1;
                        n_state = S_OUT;
                    end
                end
            end
            S_MRD: begin
                // compaction: read entry idx, then write it to idx-1
                raddr = r_idx[AW-1:0];
                n_state = S_MWR;
            end
            S_MWR: begin
                we = 1'b1;
                waddr = AW'(r_idx - 1'b1);
                wdata = rdata;
                if (r_idx + 1'b1 < r_count) begin
                    n_idx = r_idx + 1'b1;
                    n_state = S_MRD;
                end else begin
                    n_count = r_count - 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                n_ovalid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // capture now for the pick
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) r_now <= i_now_time;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_count <= '0; r_ovalid <= 1'b0; r_dv <= 1'b0;
            r_cat <= CAT_NONE;
        end else begin
            r_state <= n_state; r_count <= n_count; r_ovalid <= n_ovalid;
            r_dv <= n_dv; r_cat <= n_cat;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx; r_didx <= n_didx; r_best <= n_best; r_gap <= n_gap;
        r_bent <= n_bent; r_ost <= n_ost; r_oent <= n_oent;
    end

    assign o_valid          = r_ovalid;
    assign o_status         = r_ost;
    assign o_picked_tag     = r_oent[TAG_W-1:0];
    assign o_picked_release = r_oent[ENT_W-1:TAG_W];
endmodule

// ===== verif/testbench.sv =====
// testbench for the timed release task picker: directed and random requests
// depends on trtp_pkg and timed_release_task_picker_top
`timescale 1ns / 1ps
module testbench;
    import trtp_pkg::*;

    localparam int DEPTH = DEF_TABLE_DEPTH;

    typedef struct packed {
        logic [1:0]              status;
        logic [TAG_W-1:0]        tag;
        logic signed [REL_W-1:0] rel;
    } pick_result_t;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_ready;
    logic                    i_mode = 1'b0;
    logic [TAG_W-1:0]        i_task_tag = '0;
    logic signed [REL_W-1:0] i_release_time = '0;
    logic [NOW_W-1:0]        i_now_time = '0;
    logic                    o_valid;
    logic                    i_ready = 1'b0;
    logic [1:0]              o_status;
    logic [TAG_W-1:0]        o_picked_tag;
    logic signed [REL_W-1:0] o_picked_release;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [2:0]              paddr = '0;
    logic [31:0]             pwdata = '0;
    logic [31:0]             prdata;
    logic                    pready;

    // predictor state
    logic signed [REL_W-1:0] tbl_rel [DEPTH];
    logic [TAG_W-1:0]        tbl_tag [DEPTH];
    int                      tbl_count = 0;
    logic                    cfg_fifo = 1'b0;
    logic [15:0]             cfg_window = NEAR_WINDOW_RST;

    pick_result_t expected_q[$];
    int errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_grants = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    timed_release_task_picker_top i_dut (.*);

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // remove an entry and keep order of the rest
    function automatic pick_result_t take_entry(int idx);
        pick_result_t r;
        r.status = ST_OK;
        r.tag = tbl_tag[idx];
        r.rel = tbl_rel[idx];
        for (int k = idx; k < tbl_count - 1; k++) begin
            tbl_tag[k] = tbl_tag[k + 1];
            tbl_rel[k] = tbl_rel[k + 1];
        end
        tbl_count--;
        return r;
    endfunction

    // compute expected answer and update table model
    function automatic pick_result_t predict_answer(logic mode, logic [TAG_W-1:0] tag,
            logic signed [REL_W-1:0] rel, logic [NOW_W-1:0] now);
        pick_result_t r;
        logic signed [64:0] nw, g, best_gap;
        int best;
        bit found;
        r = '0;
        found = 0;
        best = 0;
        best_gap = 0;
        nw = $signed({17'd0, now});
        if (mode == MODE_INSERT) begin
            if (tbl_count >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                tbl_tag[tbl_count] = tag;
                tbl_rel[tbl_count] = rel;
                tbl_count++;
            end
            return r;
        end
        if (tbl_count == 0) begin
            r.status = ST_EMPTY;
            return r;
        end
        if (cfg_fifo) return take_entry(0);
        for (int k = 0; k < tbl_count; k++)
            if (tbl_rel[k] == -1) return take_entry(k);
        // most overdue
        for (int k = 0; k < tbl_count; k++) begin
            g = nw - 65'(tbl_rel[k]);
            if (g >= 0 && (!found || g > best_gap)) begin
                found = 1;
                best = k;
                best_gap = g;
            end
        end
        if (found) return take_entry(best);
        // nearest ahead within window
        for (int k = 0; k < tbl_count; k++) begin
            g = 65'(tbl_rel[k]) - nw;
            if (g > 0 && g <= $signed({49'd0, cfg_window}) && (!found || g < best_gap)) begin
                found = 1;
                best = k;
                best_gap = g;
            end
        end
        if (found) return take_entry(best);
        r.status = ST_NONE;
        return r;
    endfunction

    // send one request
    task automatic send_request(logic mode, logic [TAG_W-1:0] tag,
            logic signed [REL_W-1:0] rel, logic [NOW_W-1:0] now);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= mode;
        i_task_tag <= tag;
        i_release_time <= rel;
        i_now_time <= now;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_q = {expected_q, predict_answer(mode, tag, rel, now)};
        n_sent++;
    endtask

    // receiver stalls
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        pick_result_t e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result status=%0d tag=%0h", $time,
                         o_status, o_picked_tag);
                errors++;
            end else begin
                e = expected_q.pop_front();
                n_checked++;
                if (e.status == ST_OK && (n_checked > 0)) n_grants++;
                if (o_status !== e.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, e.status, o_status);
                    errors++;
                end
                if (o_picked_tag !== e.tag) begin
                    $display("%0t: tag expected %0h actual %0h", $time, e.tag, o_picked_tag);
                    errors++;
                end
                if (o_picked_release !== e.rel) begin
                    $display("%0t: release expected %0d actual %0d", $time, e.rel,
                             o_picked_release);
                    errors++;
                end
            end
        end
    end

    // drop valid and wait until every request has its result
    task automatic drain();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // register write over the apb port
    task automatic write_reg(logic [0:0] idx, logic [31:0] val);
        drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_FIFO_MODE) cfg_fifo = val[0];
        else cfg_window = val[15:0];
    endtask

    function automatic logic [NOW_W-1:0] rand_now();
        return NOW_W'({$urandom(), $urandom()});
    endfunction

    function automatic logic signed [REL_W-1:0] rand_rel();
        return REL_W'({$urandom(), $urandom()});
    endfunction

    task automatic pick(logic [NOW_W-1:0] now);
        send_request(MODE_PICK, TAG_W'($urandom()), rand_rel(), now);
    endtask

    task automatic insert(logic [TAG_W-1:0] tag, logic signed [REL_W-1:0] rel);
        send_request(MODE_INSERT, tag, rel, rand_now());
    endtask

    // extremes, empty, full, each pick rule
    task automatic test_directed();
        pick(48'd5);
        insert(16'hffff, -49'sd1);
        insert(16'h0000, 49'sd1000);
        insert(16'h1234, -49'sd5);
        insert(16'h5555, {1'b0, {48{1'b1}}});
        insert(16'haaaa, {1'b1, 48'd0});
        pick(48'd0);
        pick(48'hffff_ffff_ffff);
        pick(48'd0);
        pick(48'd950);
        pick(48'd0);
        pick(48'd0);
        for (int k = 0; k < DEPTH + 1; k++) insert(16'(k), 49'sd50 + k);
        pick(48'd0);
    endtask

    // windows and ties
    task automatic test_window();
        write_reg(REG_NEAR_WINDOW, 32'd0);
        while (tbl_count) pick(48'hffff_ffff_ffff);
        insert(16'd1, 49'sd10);
        insert(16'd2, 49'sd10);
        pick(48'd9);
        pick(48'd10);
        write_reg(REG_NEAR_WINDOW, 32'hffff);
        pick(48'd0);
        pick(48'd0);
    endtask

    // random traffic with clustered times so all rules fire
    task automatic test_random(int n);
        logic [NOW_W-1:0] base;
        logic signed [REL_W-1:0] r;
        int c;
        base = rand_now() >> $urandom_range(47);
        for (int k = 0; k < n; k++) begin
            c = $urandom_range(9);
            if ($urandom_range(99) < 50 + (tbl_count < 3 ? 30 : 0) - (tbl_count > 13 ? 30 : 0)) begin
                if (c == 0) r = -49'sd1;
                else if (c == 1) r = rand_rel();
                else r = $signed({1'b0, base}) + $signed(49'($urandom_range(600))) - 300;
                insert(TAG_W'($urandom()), r);
            end else begin
                pick(c == 0 ? rand_now() : NOW_W'(base + $urandom_range(300) - 150));
            end
            if ($urandom_range(99) == 0) base = rand_now() >> $urandom_range(47);
        end
    endtask

    task automatic test_fifo();
        write_reg(REG_FIFO_MODE, 32'd1);
        test_random(150);
        while (tbl_count) pick(rand_now());
        pick(rand_now());
        write_reg(REG_FIFO_MODE, 32'd0);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 25;
        recv_idle_pct = 66;
        test_directed();
        test_window();
        write_reg(REG_NEAR_WINDOW, 32'd100);
        test_random(500);
        send_idle_pct = 66;
        recv_idle_pct = 25;
        test_fifo();
        write_reg(REG_NEAR_WINDOW, 32'd400);
        test_random(450);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_NEAR_WINDOW, 32'd37);
        test_random(450);
        drain();
        repeat (50) @(posedge i_clk);
        $display("covered %0d requests, %0d results checked, %0d grants or dones",
                 n_sent, n_checked, n_grants);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end
endmodule
